// ===== rtl/core/asgr_pkg.sv =====
// ----------------------------------------------------------------------------
// asgr_pkg: shared types and constants of the SGR attribute parser
// Item structs, parser state, configuration set and code point constants.
// ----------------------------------------------------------------------------
package asgr_pkg;

  // Field widths
  localparam int CP_W    = 21;
  localparam int COLOR_W = 8;
  localparam int MODE_W  = 7;
  localparam int NUM_W   = 8;

  // Code points that steer the parser
  localparam logic [CP_W-1:0] CP_LF  = 21'h00000A;
  localparam logic [CP_W-1:0] CP_ESC = 21'h00001B;
  localparam logic [CP_W-1:0] CP_LBR = 21'h00005B;
  localparam logic [CP_W-1:0] CP_M   = 21'h00006D;
  localparam logic [CP_W-1:0] CP_D0  = 21'h000030;
  localparam logic [CP_W-1:0] CP_D9  = 21'h000039;

  // SGR parameter values with a special meaning
  localparam logic [NUM_W-1:0] SGR_RESET   = 8'd0;
  localparam logic [NUM_W-1:0] SGR_FG_EXT  = 8'd38;
  localparam logic [NUM_W-1:0] SGR_BG_EXT  = 8'd48;
  localparam logic [NUM_W-1:0] SGR_PALETTE = 8'd5;

  // Mode bit i is set by MODE_SET_CODE[i] and cleared by MODE_CLR_CODE[i]
  localparam logic [NUM_W-1:0] MODE_SET_CODE [0:MODE_W-1] =
    '{8'd1, 8'd2, 8'd3, 8'd4, 8'd7, 8'd8, 8'd9};
  localparam logic [NUM_W-1:0] MODE_CLR_CODE [0:MODE_W-1] =
    '{8'd22, 8'd22, 8'd23, 8'd24, 8'd27, 8'd28, 8'd29};

  // Configuration register reset values
  localparam logic [COLOR_W-1:0] INIT_FORE_RST = 8'd7;
  localparam logic [COLOR_W-1:0] INIT_BACK_RST = 8'd232;
  localparam logic [MODE_W-1:0]  INIT_MODE_RST = 7'd0;

  // Configuration register indexes (byte address / 4)
  localparam int ADDR_W = 4;
  localparam logic [1:0] REG_INIT_FORE = 2'd0;
  localparam logic [1:0] REG_INIT_BACK = 2'd1;
  localparam logic [1:0] REG_INIT_MODE = 2'd2;

  // Result kinds
  localparam logic KIND_GLYPH   = 1'b0;
  localparam logic KIND_NEWLINE = 1'b1;

  typedef enum logic [1:0] {
    PH_PLAIN = 2'd0,
    PH_ESC   = 2'd1,
    PH_SEQ   = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    PEND_NONE = 3'd0,
    PEND_FG5  = 3'd1,
    PEND_FGN  = 3'd2,
    PEND_BG5  = 3'd3,
    PEND_BGN  = 3'd4
  } pend_t;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            first_of_text;
  } in_item_t;

  typedef struct packed {
    logic               item_kind;
    logic [CP_W-1:0]    glyph_code;
    logic [COLOR_W-1:0] glyph_forecolor;
    logic [COLOR_W-1:0] glyph_backcolor;
    logic [MODE_W-1:0]  glyph_mode;
  } out_item_t;

  typedef struct packed {
    logic [COLOR_W-1:0] init_fore;
    logic [COLOR_W-1:0] init_back;
    logic [MODE_W-1:0]  init_mode;
  } cfg_t;

  typedef struct packed {
    logic [COLOR_W-1:0] fore;
    logic [COLOR_W-1:0] back;
    logic [MODE_W-1:0]  mode;
    phase_t             phase;
    logic [NUM_W-1:0]   num;
    logic               num_open;
    pend_t              pend;
  } sgr_state_t;

endpackage

// ===== rtl/core/ansi_sgr_attribute_parser.sv =====
// ----------------------------------------------------------------------------
// ansi_sgr_attribute_parser: ANSI SGR attribute parser, top level
// Input register, parser step logic, parser state and result register.
// ----------------------------------------------------------------------------
// The block takes one decoded code point per cycle while it is not stalled
// and returns glyphs and newline markers tagged with the colour and style in
// force, consuming ESC [ ... m sequences on the way. Each code point passes
// the input register, then the step logic and the result register, where its
// result is offered to the receiver. Both channels stall together only when
// the result register is full and not taken. Write the initial attribute
// registers only while the block is idle.
// ----------------------------------------------------------------------------
module ansi_sgr_attribute_parser (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  asgr_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output asgr_pkg::out_item_t         out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [asgr_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  asgr_pkg::cfg_t       cfg;
  logic                 s1_valid_r;
  asgr_pkg::in_item_t   s1_item_r;
  asgr_pkg::sgr_state_t state_r;
  asgr_pkg::sgr_state_t state_nxt;
  logic                 emit;
  asgr_pkg::out_item_t  result;
  logic                 out_valid_r;
  asgr_pkg::out_item_t  out_item_r;
  logic                 advance;

  asgr_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  asgr_step u_step (
    .state_i  (state_r),
    .cfg_i    (cfg),
    .item_i   (s1_item_r),
    .state_o  (state_nxt),
    .emit_o   (emit),
    .result_o (result)
  );

  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // Input register: take a new transfer whenever it is empty or the held item moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item_r <= in_data;
    end
  end

  // Parser state: advance once per consumed code point
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.fore     <= asgr_pkg::INIT_FORE_RST;
      state_r.back     <= asgr_pkg::INIT_BACK_RST;
      state_r.mode     <= asgr_pkg::INIT_MODE_RST;
      state_r.phase    <= asgr_pkg::PH_PLAIN;
      state_r.num      <= '0;
      state_r.num_open <= 1'b0;
      state_r.pend     <= asgr_pkg::PEND_NONE;
    end else if (s1_valid_r && advance) begin
      state_r <= state_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r && emit) begin
      out_item_r <= result;
    end
  end

  // A digit run is only open inside a sequence
  a_num_in_seq : assert property (@(posedge clk) disable iff (!rst_n)
    state_r.num_open |-> (state_r.phase == asgr_pkg::PH_SEQ))
    else $error("digit run open outside a control sequence");

  // The final byte of a sequence returns to plain text with nothing pending
  a_seq_close : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && advance && !s1_item_r.first_of_text
     && state_r.phase == asgr_pkg::PH_SEQ && s1_item_r.code_point == asgr_pkg::CP_M)
    |=> (state_r.phase == asgr_pkg::PH_PLAIN && state_r.pend == asgr_pkg::PEND_NONE))
    else $error("sequence not closed by its final byte");

  // A newline marker carries code point zero
  a_newline_code : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.item_kind == asgr_pkg::KIND_NEWLINE)
    |-> (out_item_r.glyph_code == '0))
    else $error("newline marker with non-zero code");

  // A new result only follows a consumed input item
  a_result_source : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("result without a consumed item");

endmodule

// ===== rtl/core/asgr_regs.sv =====
// ----------------------------------------------------------------------------
// asgr_regs: configuration registers
// APB-style register file holding the initial colours and mode.
// ----------------------------------------------------------------------------
module asgr_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [asgr_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output asgr_pkg::cfg_t                cfg_o
);

  asgr_pkg::cfg_t cfg_r;
  logic           wr_en;
  logic [1:0]     reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[3:2];
  assign cfg_o   = cfg_r;

  // Write on the access phase of a transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.init_fore <= asgr_pkg::INIT_FORE_RST;
      cfg_r.init_back <= asgr_pkg::INIT_BACK_RST;
      cfg_r.init_mode <= asgr_pkg::INIT_MODE_RST;
    end else if (wr_en) begin
      case (reg_idx)
        asgr_pkg::REG_INIT_FORE: cfg_r.init_fore <= pwdata[asgr_pkg::COLOR_W-1:0];
        asgr_pkg::REG_INIT_BACK: cfg_r.init_back <= pwdata[asgr_pkg::COLOR_W-1:0];
        asgr_pkg::REG_INIT_MODE: cfg_r.init_mode <= pwdata[asgr_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back, zero extended
  always_comb begin
    case (reg_idx)
      asgr_pkg::REG_INIT_FORE: prdata = {24'd0, cfg_r.init_fore};
      asgr_pkg::REG_INIT_BACK: prdata = {24'd0, cfg_r.init_back};
      asgr_pkg::REG_INIT_MODE: prdata = {25'd0, cfg_r.init_mode};
      default:                 prdata = 32'd0;
    endcase
  end

endmodule

// ===== rtl/core/asgr_step.sv =====
// ----------------------------------------------------------------------------
// asgr_step: parser step logic
// Next parser state and optional result for one code point.
// ----------------------------------------------------------------------------
module asgr_step (
  input  asgr_pkg::sgr_state_t state_i,
  input  asgr_pkg::cfg_t       cfg_i,
  input  asgr_pkg::in_item_t   item_i,
  output asgr_pkg::sgr_state_t state_o,
  output logic                 emit_o,
  output asgr_pkg::out_item_t  result_o
);

  asgr_pkg::sgr_state_t         cur;
  asgr_pkg::sgr_state_t         nxt;
  logic [asgr_pkg::CP_W-1:0]    cp;
  logic                         is_digit;
  logic                         plain;
  logic                         param_go;
  logic                         seq_end;
  logic [asgr_pkg::NUM_W-1:0]   num_base;
  logic [asgr_pkg::NUM_W-1:0]   v;
  logic [asgr_pkg::MODE_W-1:0]  set_hit;
  logic [asgr_pkg::MODE_W-1:0]  clr_hit;

  assign cp       = item_i.code_point;
  assign is_digit = (cp >= asgr_pkg::CP_D0) && (cp <= asgr_pkg::CP_D9);
  assign num_base = cur.num_open ? cur.num : '0;
  assign v        = cur.num;

  // Match the finished parameter against the style code tables
  always_comb begin
    for (int i = 0; i < asgr_pkg::MODE_W; i++) begin
      set_hit[i] = (asgr_pkg::MODE_SET_CODE[i] == v);
      clr_hit[i] = (asgr_pkg::MODE_CLR_CODE[i] == v);
    end
  end

  always_comb begin
    // Start of a new text: restore attributes and drop any open sequence
    cur = state_i;
    if (item_i.first_of_text) begin
      cur.fore     = cfg_i.init_fore;
      cur.back     = cfg_i.init_back;
      cur.mode     = cfg_i.init_mode;
      cur.phase    = asgr_pkg::PH_PLAIN;
      cur.num      = '0;
      cur.num_open = 1'b0;
      cur.pend     = asgr_pkg::PEND_NONE;
    end

    nxt      = cur;
    plain    = 1'b0;
    param_go = 1'b0;
    seq_end  = 1'b0;
    emit_o   = 1'b0;

    // Advance the escape phase
    case (cur.phase)
      asgr_pkg::PH_ESC: begin
        if (cp == asgr_pkg::CP_LBR) begin
          nxt.phase    = asgr_pkg::PH_SEQ;
          nxt.num      = '0;
          nxt.num_open = 1'b0;
          nxt.pend     = asgr_pkg::PEND_NONE;
        end else begin
          nxt.phase = asgr_pkg::PH_PLAIN;
          plain     = 1'b1;
        end
      end
      asgr_pkg::PH_SEQ: begin
        if (is_digit) begin
          nxt.num      = asgr_pkg::NUM_W'(num_base * 8'd10) + {4'd0, cp[3:0]};
          nxt.num_open = 1'b1;
        end else begin
          param_go     = cur.num_open;
          nxt.num_open = 1'b0;
          seq_end      = (cp == asgr_pkg::CP_M);
        end
      end
      default: begin
        nxt.phase = asgr_pkg::PH_PLAIN;
        plain     = 1'b1;
      end
    endcase

    // Apply a parameter whose digit run has just ended
    if (param_go) begin
      case (cur.pend)
        asgr_pkg::PEND_FGN: begin
          nxt.fore = v;
          nxt.pend = asgr_pkg::PEND_NONE;
        end
        asgr_pkg::PEND_BGN: begin
          nxt.back = v;
          nxt.pend = asgr_pkg::PEND_NONE;
        end
        default: begin
          if (cur.pend == asgr_pkg::PEND_FG5 && v == asgr_pkg::SGR_PALETTE) begin
            nxt.pend = asgr_pkg::PEND_FGN;
          end else if (cur.pend == asgr_pkg::PEND_BG5 && v == asgr_pkg::SGR_PALETTE) begin
            nxt.pend = asgr_pkg::PEND_BGN;
          end else begin
            nxt.pend = asgr_pkg::PEND_NONE;
            if (v == asgr_pkg::SGR_FG_EXT) begin
              nxt.pend = asgr_pkg::PEND_FG5;
            end else if (v == asgr_pkg::SGR_BG_EXT) begin
              nxt.pend = asgr_pkg::PEND_BG5;
            end else if (v == asgr_pkg::SGR_RESET) begin
              nxt.fore = cfg_i.init_fore;
              nxt.back = cfg_i.init_back;
              nxt.mode = cfg_i.init_mode;
            end else if (|set_hit) begin
              nxt.mode = cur.mode | set_hit;
            end else begin
              nxt.mode = cur.mode & ~clr_hit;
            end
          end
        end
      endcase
    end

    // Close the sequence on its final byte
    if (seq_end) begin
      nxt.phase = asgr_pkg::PH_PLAIN;
      nxt.pend  = asgr_pkg::PEND_NONE;
      nxt.num   = '0;
    end

    // Plain text: open an escape or emit the character
    if (plain) begin
      if (cp == asgr_pkg::CP_ESC) begin
        nxt.phase = asgr_pkg::PH_ESC;
      end else begin
        emit_o = 1'b1;
      end
    end

    state_o = nxt;
  end

  // Result carries the attributes in force before this code point
  always_comb begin
    result_o.item_kind       = (cp == asgr_pkg::CP_LF) ? asgr_pkg::KIND_NEWLINE
                                                       : asgr_pkg::KIND_GLYPH;
    result_o.glyph_code      = (cp == asgr_pkg::CP_LF) ? '0 : cp;
    result_o.glyph_forecolor = cur.fore;
    result_o.glyph_backcolor = cur.back;
    result_o.glyph_mode      = cur.mode;
  end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the ANSI SGR attribute parser
// Code points are pushed through the valid/ready input channel and every
// glyph or newline marker on the result channel is compared, field by field,
// with the output of a cycle-free attribute tracker kept in a small
// scoreboard class. The initial attribute registers are written over the
// APB-style port between phases, and both channels idle and stall at random except in the last phase.
// ----------------------------------------------------------------------------
module tb_top;
  import asgr_pkg::*;

  localparam int HOLD_CYCLES = 300;   // long receiver hold-off
  localparam int WATCHDOG    = 5000;  // cycles without any transfer
  localparam int SETTLE      = 6;     // cycles for the pipeline to empty
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 185;
  localparam int SHOW_MAX    = 10;

  localparam logic [CP_W-1:0] CP_SEMI  = 21'h00003B;
  localparam logic [CP_W-1:0] CP_COLON = 21'h00003A;

  // --------------------------------------------------------------------------
  // Attribute tracker and store of expected glyphs
  // --------------------------------------------------------------------------
  class sgr_scoreboard;
    cfg_t             regs;
    logic [COLOR_W-1:0] fore;
    logic [COLOR_W-1:0] back;
    logic [MODE_W-1:0]  mode;
    phase_t           phase;
    logic [NUM_W-1:0] num;
    logic             num_open;
    pend_t            pend;
    out_item_t        glyph_q[$];
    int               errors;
    int               checked;
    int               restarts;

    function new();
      regs.init_fore = INIT_FORE_RST;
      regs.init_back = INIT_BACK_RST;
      regs.init_mode = INIT_MODE_RST;
      errors   = 0;
      checked  = 0;
      restarts = 0;
      restart_text();
    endfunction

    function void restore_attrs();
      fore = regs.init_fore;
      back = regs.init_back;
      mode = regs.init_mode;
    endfunction

    function void restart_text();
      restore_attrs();
      phase    = PH_PLAIN;
      num      = '0;
      num_open = 1'b0;
      pend     = PEND_NONE;
    endfunction

    function void set_register(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_INIT_FORE: regs.init_fore = value[COLOR_W-1:0];
        REG_INIT_BACK: regs.init_back = value[COLOR_W-1:0];
        REG_INIT_MODE: regs.init_mode = value[MODE_W-1:0];
        default: ;
      endcase
    endfunction

    function void fail(string what);
      errors++;
      if (errors <= SHOW_MAX) begin
        $display("[%0t] ERROR: %s", $realtime, what);
      end
    endfunction

    // Act on one finished SGR parameter
    function void apply_param(logic [NUM_W-1:0] v);
      bit hit;
      hit = 1'b0;
      if (pend == PEND_FGN) begin
        fore = v;
        pend = PEND_NONE;
        return;
      end
      if (pend == PEND_BGN) begin
        back = v;
        pend = PEND_NONE;
        return;
      end
      if (pend == PEND_FG5 && v == SGR_PALETTE) begin
        pend = PEND_FGN;
        return;
      end
      if (pend == PEND_BG5 && v == SGR_PALETTE) begin
        pend = PEND_BGN;
        return;
      end
      pend = PEND_NONE;
      if (v == SGR_FG_EXT) begin
        pend = PEND_FG5;
        return;
      end
      if (v == SGR_BG_EXT) begin
        pend = PEND_BG5;
        return;
      end
      if (v == SGR_RESET) begin
        restore_attrs();
        return;
      end
      for (int b = 0; b < MODE_W; b++) begin
        if (!hit && MODE_SET_CODE[b] == v) begin
          mode[b] = 1'b1;
          hit = 1'b1;
        end
      end
      if (!hit) begin
        for (int b = 0; b < MODE_W; b++) begin
          if (MODE_CLR_CODE[b] == v) mode[b] = 1'b0;
        end
      end
    endfunction

    // Plain text: ESC opens a sequence, anything else comes out
    function void plain_char(logic [CP_W-1:0] cp);
      out_item_t g;
      if (cp == CP_ESC) begin
        phase = PH_ESC;
        return;
      end
      g.item_kind       = (cp == CP_LF) ? KIND_NEWLINE : KIND_GLYPH;
      g.glyph_code      = (cp == CP_LF) ? '0 : cp;
      g.glyph_forecolor = fore;
      g.glyph_backcolor = back;
      g.glyph_mode      = mode;
      glyph_q.insert(glyph_q.size(), g);
    endfunction

    // Note one accepted code point
    function void note_input(in_item_t item);
      logic [CP_W-1:0] cp;
      cp = item.code_point;
      if (item.first_of_text) begin
        restart_text();
        restarts++;
      end
      case (phase)
        PH_ESC: begin
          if (cp == CP_LBR) begin
            phase    = PH_SEQ;
            num      = '0;
            num_open = 1'b0;
            pend     = PEND_NONE;
          end else begin
            phase = PH_PLAIN;
            plain_char(cp);
          end
        end
        PH_SEQ: begin
          if (cp >= CP_D0 && cp <= CP_D9) begin
            if (!num_open) begin
              num      = '0;
              num_open = 1'b1;
            end
            num = NUM_W'(num * 10 + (cp - CP_D0));
          end else begin
            if (num_open) begin
              num_open = 1'b0;
              apply_param(num);
            end
            if (cp == CP_M) begin
              phase = PH_PLAIN;
              pend  = PEND_NONE;
              num   = '0;
            end
          end
        end
        default: begin
          phase = PH_PLAIN;
          plain_char(cp);
        end
      endcase
    endfunction

    // Compare one result transfer with the oldest expected glyph
    function void check_result(out_item_t got);
      out_item_t exp_g;
      if (glyph_q.size() == 0) begin
        fail($sformatf("result with nothing expected: kind %0d code %h",
                       got.item_kind, got.glyph_code));
        return;
      end
      exp_g = glyph_q.pop_front();
      checked++;
      if (got.item_kind !== exp_g.item_kind ||
          got.glyph_code !== exp_g.glyph_code ||
          got.glyph_forecolor !== exp_g.glyph_forecolor ||
          got.glyph_backcolor !== exp_g.glyph_backcolor ||
          got.glyph_mode !== exp_g.glyph_mode) begin
        fail($sformatf({"glyph mismatch (exp/act): kind %0d/%0d code %h/%h ",
                        "fore %0d/%0d back %0d/%0d mode %h/%h"},
                       exp_g.item_kind, got.item_kind,
                       exp_g.glyph_code, got.glyph_code,
                       exp_g.glyph_forecolor, got.glyph_forecolor,
                       exp_g.glyph_backcolor, got.glyph_backcolor,
                       exp_g.glyph_mode, got.glyph_mode));
      end
    endfunction

    function int pending();
      return glyph_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals, clock and block
  // --------------------------------------------------------------------------
  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  in_item_t            in_data;
  logic                out_valid;
  logic                out_ready;
  out_item_t           out_data;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  sgr_scoreboard sb = new();

  bit idle_on       = 1'b1;
  bit allow_restart = 1'b0;
  bit next_first    = 1'b0;
  bit long_hold     = 1'b0;
  int n_sent        = 0;
  int n_settings    = 0;
  int quiet_cycles  = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ansi_sgr_attribute_parser i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Note accepted code points and check result transfers
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_input(in_data);
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG);
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: random stall bursts and one long hold-off on request
  initial begin
    out_ready = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driving tasks
  // --------------------------------------------------------------------------
  // Offer one code point and hold it until the transfer
  task automatic send_cp(input logic [CP_W-1:0] cp);
    in_item_t item;
    item.code_point    = cp;
    item.first_of_text = next_first || (allow_restart && $urandom_range(0, 79) == 0);
    next_first = 1'b0;
    if (idle_on && $urandom_range(0, 15) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    n_sent++;
  endtask

  // Stop sending until every expected glyph is back and the pipe is empty
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_register(idx, value);
  endtask

  task automatic cfg_read_check(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== value) begin
      sb.fail($sformatf("register %0d reads %h, expected %h", idx, prdata, value));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Apply one setting of the three initial attribute registers
  task automatic apply_setting(input cfg_t c);
    cfg_write(REG_INIT_FORE, 32'(c.init_fore));
    cfg_write(REG_INIT_BACK, 32'(c.init_back));
    cfg_write(REG_INIT_MODE, 32'(c.init_mode));
    cfg_read_check(REG_INIT_FORE, 32'(c.init_fore));
    cfg_read_check(REG_INIT_BACK, 32'(c.init_back));
    cfg_read_check(REG_INIT_MODE, 32'(c.init_mode));
    n_settings++;
  endtask

  // Decimal digit run, now and then with a leading zero
  task automatic send_number(input int v);
    int digs[$];
    int x;
    x = v;
    do begin
      digs.push_front(x % 10);
      x = x / 10;
    end while (x > 0);
    if ($urandom_range(0, 7) == 0) send_cp(CP_D0);
    foreach (digs[k]) send_cp(CP_W'(CP_D0 + digs[k]));
  endtask

  // Parameter separator: mostly ';', sometimes other non-digits
  task automatic send_separator();
    case ($urandom_range(0, 19))
      0:       send_cp(CP_COLON);
      1:       send_cp(CP_LF);
      2:       send_cp(CP_ESC);
      3:       send_cp(CP_W'($urandom_range(21'h80, 21'h1FFFFF)));
      default: send_cp(CP_SEMI);
    endcase
  endtask

  function automatic logic [CP_W-1:0] plain_cp();
    case ($urandom_range(0, 9))
      6, 7:    return CP_W'($urandom_range(21'h80, 21'h10FFFF));
      8:       return CP_W'($urandom_range(21'h110000, 21'h1FFFFF));
      9:       return CP_W'($urandom_range(0, 31));
      default: return CP_W'($urandom_range(21'h20, 21'h7E));
    endcase
  endfunction

  function automatic int colour_prefix();
    return ($urandom_range(0, 1) == 0) ? int'(SGR_FG_EXT) : int'(SGR_BG_EXT);
  endfunction

  // One ESC [ ... m sequence with random parameters, now and then cut off by a new text
  task automatic emit_sgr();
    int n_params;
    int v;
    int ext;
    send_cp(CP_ESC);
    send_cp(CP_LBR);
    n_params = $urandom_range(0, 4);
    for (int p = 0; p < n_params; p++) begin
      if (p > 0) send_separator();
      case ($urandom_range(0, 9))
        0: send_number(int'(SGR_RESET));
        1, 9: send_number(int'(MODE_SET_CODE[$urandom_range(0, MODE_W-1)]));
        2: send_number(int'(MODE_CLR_CODE[$urandom_range(0, MODE_W-1)]));
        3, 4: begin
          send_number(colour_prefix());
          send_separator();
          send_number(int'(SGR_PALETTE));
          send_separator();
          send_number($urandom_range(0, 255));
        end
        5: begin
          // colour prefix followed by something other than the palette selector
          send_number(colour_prefix());
          send_separator();
          v = $urandom_range(0, 255);
          if (v == int'(SGR_PALETTE)) v = v + 1;
          send_number(v);
        end
        6: send_number($urandom_range(0, 999));
        default: ;
      endcase
    end
    // colour prefix cut short by the terminator
    if (n_params > 0 && $urandom_range(0, 7) == 0) begin
      ext = colour_prefix();
      send_separator();
      send_number(ext);
      if ($urandom_range(0, 1) == 0) begin
        send_separator();
        send_number(int'(SGR_PALETTE));
      end
    end
    if ($urandom_range(0, 11) == 0) begin
      next_first = 1'b1;
    end else begin
      send_cp(CP_M);
    end
  endtask

  task automatic run_random(input int count, input int phase_no);
    int start;
    int r;
    logic [CP_W-1:0] cp;
    bit held;
    bit paused;
    start  = n_sent;
    held   = 1'b0;
    paused = 1'b0;
    while (n_sent - start < count) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        emit_sgr();
      end else if (r < 75) begin
        repeat ($urandom_range(1, 6)) send_cp(plain_cp());
      end else if (r < 85) begin
        send_cp(CP_LF);
      end else if (r < 93) begin
        // stray escape
        send_cp(CP_ESC);
        cp = plain_cp();
        if (cp == CP_LBR) cp = CP_M;
        send_cp(cp);
      end else begin
        send_cp(CP_W'($urandom_range(0, 21'h1FFFFF)));
      end
      if (phase_no == 2 && !held && n_sent - start > count / 3) begin
        long_hold = 1'b1;
        held      = 1'b1;
      end
      if (phase_no == 3 && !paused && n_sent - start > count / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end
  endtask

  function automatic cfg_t setting_for(input int phase_no);
    cfg_t c;
    case (phase_no)
      0: c = '{init_fore: 8'd0,   init_back: 8'd0,   init_mode: 7'd0};
      1: c = '{init_fore: 8'd255, init_back: 8'd255, init_mode: 7'h7F};
      4: c = '{init_fore: 8'd255, init_back: 8'd0,   init_mode: 7'h55};
      default: begin
        c.init_fore = COLOR_W'($urandom_range(0, 255));
        c.init_back = COLOR_W'($urandom_range(0, 255));
        c.init_mode = MODE_W'($urandom_range(0, 127));
      end
    endcase
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Sequence of the run
  // --------------------------------------------------------------------------
  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, colour setting, empty and stray escapes,
    // and a sequence cut off by a new text, all under reset register values
    next_first = 1'b1;
    send_cp(CP_W'("A"));
    send_cp(21'h1FFFFF);
    send_cp(21'h000000);
    send_cp(CP_LF);
    send_cp(CP_ESC);
    send_cp(CP_LBR);
    send_number(22);
    send_cp(CP_SEMI);
    send_number(48);
    send_cp(CP_SEMI);
    send_number(5);
    send_cp(CP_SEMI);
    send_number(9);
    send_cp(CP_M);
    send_cp(CP_W'("x"));
    send_cp(CP_ESC);
    send_cp(CP_W'("q"));
    send_cp(CP_ESC);
    send_cp(CP_LBR);
    send_cp(CP_M);
    send_cp(CP_W'("y"));
    send_cp(CP_ESC);
    send_cp(CP_LBR);
    send_cp(CP_D0 + 21'd1);
    next_first = 1'b1;
    send_cp(CP_W'("z"));

    // random phases, each under its own register setting
    allow_restart = 1'b1;
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      apply_setting(setting_for(p));
      if (p == PHASES - 1) idle_on = 1'b0;
      run_random(PHASE_ITEMS, p);
    end

    // drain and report
    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.pending() != 0) sb.fail($sformatf("%0d glyphs never came", sb.pending()));
    $display("Covered %0d code points (%0d new-text restarts) under %0d register settings",
             n_sent, sb.restarts, n_settings + 1);
    $display("%0d glyphs and newline markers checked, %0d errors", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/asgr_pkg.sv
rtl/core/asgr_regs.sv
rtl/core/asgr_step.sv
rtl/core/ansi_sgr_attribute_parser.sv
tb/tb_top.sv
